// ===== design/block_binding_table_assert.svh =====
// assertion macros for the block binding table
// used by design/block_binding_table.sv, no other dependencies
`ifndef BLOCK_BINDING_TABLE_ASSERT_SVH
`define BLOCK_BINDING_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// clocked property with reset disable and a given message
`define BBT_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property with the default message
`define BBT_ASSERT(label, clk, rst_n, prop) \
  `BBT_ASSERT_MSG(label, clk, rst_n, prop, "block_binding_table assertion failed")

`else

`define BBT_ASSERT_MSG(label, clk, rst_n, prop, msg)
`define BBT_ASSERT(label, clk, rst_n, prop)

`endif

`endif

// ===== design/bbt_pkg.sv =====
// shared types and codes for the block binding table
// no dependencies; imported by bbt_ram and block_binding_table
`default_nettype none

package bbt_pkg;

  localparam int ID_W      = 31;
  localparam int POS_W     = 16;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int LEN_OUT_W = 11;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request codes
  localparam req_t REQ_BIND   = 3'd0;
  localparam req_t REQ_UNBIND = 3'd1;
  localparam req_t REQ_LOOKUP = 3'd2;
  localparam req_t REQ_APPEND = 3'd3;
  localparam req_t REQ_POP    = 3'd4;
  localparam req_t REQ_SWAP   = 3'd5;
  localparam req_t REQ_RESIZE = 3'd6;
  localparam req_t REQ_CLEAR  = 3'd7;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // one table entry as held in the memory
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/bbt_ram.sv =====
// entry memory of the block binding table: one write and one read port
// registered read data; depends on bbt_pkg
`default_nettype none

module bbt_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire bbt_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output bbt_pkg::entry_t      rdata
);

  import bbt_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/block_binding_table.sv =====
// Block binding table: one request taken at a time, one result per request.
// Steps from input transfer to result: bind, unbind, append, clear, a
// shrinking resize and any failing request go from decode to the result;
// lookup and pop add one memory read; swap makes two reads and two writes on
// the single memory port pair; a growing resize writes one empty entry a cycle
// up to the new length. The next request is taken in the cycle after the result is registered.
// Reset clears the sequencer, the output valid and the length; no memory pass.
`default_nettype none
`include "block_binding_table_assert.svh"

module block_binding_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // position_a [15:0], position_b [31:16], pool_id [62:32],
  // entry_present [63], new_length [79:64]
  input  wire logic [79:0] in_tdata,
  // req_type [2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status [1:0], found [2], pool_id_out [33:3], length_out [44:34], zero [47:45]
  output logic [47:0]      out_tdata
);

  import bbt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SWAP_A = 3'd3;
  localparam logic [2:0] S_SWAP_B = 3'd4;
  localparam logic [2:0] S_SWAP_W = 3'd5;
  localparam logic [2:0] S_SWEEP  = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [47:0]      out_tdata_r, out_tdata_nxt;

  req_t             req_r, req_nxt;
  logic [POS_W-1:0] pa_r, pa_nxt;
  logic [POS_W-1:0] pb_r, pb_nxt;
  logic [ID_W-1:0]  bid_r, bid_nxt;
  logic             pres_r, pres_nxt;
  logic [POS_W-1:0] nlen_r, nlen_nxt;
  entry_t           tmp_r, tmp_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  entry_t           ram_rdata;

  logic [CW-1:0]    len_w, pa_w, pb_w, nlen_w;
  logic [LW-1:0]    len_m1;
  logic             a_oor, b_oor, out_free;
  logic             in_fire;

  // entry memory
  bbt_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // range checks on a common width
  assign len_w    = CW'(len_r);
  assign pa_w     = CW'(pa_r);
  assign pb_w     = CW'(pb_r);
  assign nlen_w   = CW'(nlen_r);
  assign len_m1   = len_r - LW'(1);
  assign a_oor    = pa_w >= len_w;
  assign b_oor    = pb_w >= len_w;
  assign out_free = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // request sequencer: read, modify, write back
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    req_nxt        = req_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    bid_nxt        = bid_r;
    pres_nxt       = pres_r;
    nlen_nxt       = nlen_r;
    tmp_nxt        = tmp_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_id_nxt     = res_id_r;
    ram_we         = 1'b0;
    ram_waddr      = pa_r[AW-1:0];
    ram_wdata      = '0;
    ram_raddr      = pa_r[AW-1:0];

    // result taken downstream
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = in_tuser;
          pa_nxt    = in_tdata[15:0];
          pb_nxt    = in_tdata[31:16];
          bid_nxt   = in_tdata[62:32];
          pres_nxt  = in_tdata[63];
          nlen_nxt  = in_tdata[79:64];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_nxt = ST_OK;
        res_found_nxt  = 1'b0;
        res_id_nxt     = '0;
        state_nxt      = S_RESP;
        case (req_r)
          REQ_BIND: begin
            if (a_oor) begin
              res_status_nxt = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{valid: 1'b1, id: bid_r};
            end
          end
          REQ_UNBIND: begin
            if (a_oor) begin
              res_status_nxt = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{valid: 1'b0, id: bid_r};
            end
          end
          REQ_LOOKUP: begin
            if (a_oor) begin
              res_status_nxt = ST_RANGE;
            end else begin
              state_nxt = S_READ;
            end
          end
          REQ_APPEND: begin
            if (len_w == DEPTH_C) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = len_r[AW-1:0];
              ram_wdata = '{valid: pres_r, id: bid_r};
              len_nxt   = len_r + LW'(1);
            end
          end
          REQ_POP: begin
            if (len_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              ram_raddr = len_m1[AW-1:0];
              len_nxt   = len_m1;
              state_nxt = S_READ;
            end
          end
          REQ_SWAP: begin
            if (a_oor || b_oor) begin
              res_status_nxt = ST_RANGE;
            end else begin
              state_nxt = S_SWAP_A;
            end
          end
          REQ_RESIZE: begin
            if (nlen_w > DEPTH_C) begin
              res_status_nxt = ST_FULL;
            end else if (nlen_w > len_w) begin
              state_nxt = S_SWEEP;
            end else begin
              len_nxt = LW'(nlen_r);
            end
          end
          REQ_CLEAR: begin
            len_nxt = '0;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      // lookup or pop data back from memory
      S_READ: begin
        res_found_nxt = ram_rdata.valid;
        res_id_nxt    = ram_rdata.valid ? ram_rdata.id : '0;
        state_nxt     = S_RESP;
      end

      // first swap operand arrives, second read issued
      S_SWAP_A: begin
        tmp_nxt   = ram_rdata;
        ram_raddr = pb_r[AW-1:0];
        state_nxt = S_SWAP_B;
      end

      // second operand goes to the first position
      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = pa_r[AW-1:0];
        ram_wdata = ram_rdata;
        state_nxt = S_SWAP_W;
      end

      // first operand goes to the second position
      S_SWAP_W: begin
        ram_we    = 1'b1;
        ram_waddr = pb_r[AW-1:0];
        ram_wdata = tmp_r;
        state_nxt = S_RESP;
      end

      // growing resize: write one empty entry a cycle
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = len_r[AW-1:0];
        ram_wdata = '0;
        len_nxt   = len_r + LW'(1);
        if ((len_w + CW'(1)) == nlen_w) begin
          state_nxt = S_RESP;
        end
      end

      // load the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, LEN_OUT_W'(len_r), res_id_r, res_found_r, res_status_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_tdata_r  <= out_tdata_nxt;
    req_r        <= req_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    bid_r        <= bid_nxt;
    pres_r       <= pres_nxt;
    nlen_r       <= nlen_nxt;
    tmp_r        <= tmp_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_id_r     <= res_id_nxt;
  end

  // checks
  `BBT_ASSERT(a_len_cap, clk, rst_n, len_w <= DEPTH_C)
  `BBT_ASSERT(a_sweep_step, clk, rst_n, (state_r == S_SWEEP) |=> (len_r == $past(len_r) + LW'(1)))
  `BBT_ASSERT(a_idle_no_write, clk, rst_n, (state_r == S_IDLE) |-> !ram_we)
  `BBT_ASSERT_MSG(a_accept_decode, clk, rst_n, in_fire |=> (state_r == S_DECODE), "no decode")

endmodule

`default_nettype wire
